// ===== hw/rtl/sci_pkg.sv =====
package sci_pkg;

    // coordinate, difference and quadratic coefficient widths
    localparam int W_C   = 32;
    localparam int W_R2  = 31;
    localparam int W_D   = 33;
    localparam int W_V   = 67;
    // discriminant and its integer root
    localparam int W_Q   = 136;
    localparam int W_RT  = W_Q / 2;
    // rounding numerator and quotient
    localparam int W_N   = 102;
    localparam int W_QT  = 32;
    // pipelined multiplier depth
    localparam int MUL_LAT = 5;

    localparam int IN_W  = 224;
    localparam int OUT_W = 72;
    localparam int RES_W = 66;

    // per-item context carried down the pipe
    typedef struct packed {
        logic signed [W_C-1:0] sx;
        logic signed [W_C-1:0] sy;
        logic signed [W_D-1:0] dx;
        logic signed [W_D-1:0] dy;
        logic signed [W_V-1:0] a;
        logic signed [W_V-1:0] h;
        logic signed [W_V-1:0] c;
        logic signed [W_V-1:0] e;
        logic signed [W_V-1:0] ah;
        logic                  far_ok;
        logic                  found;
    } t_ctx;

endpackage

// ===== hw/rtl/sci_mul.sv =====
module sci_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [WA-1:0]      i_a,
    input  logic signed [WB-1:0]      i_b,
    output logic signed [WA+WB-1:0]   o_p
);

    localparam int HA = WA / 2;
    localparam int HB = WB / 2;
    localparam int WP = WA + WB;

    logic [WA-1:0]         r_ma;
    logic [WB-1:0]         r_mb;
    logic [3:0]            r_sg;
    logic [HA+HB-1:0]      r_pll;
    logic [HA+WB-HB-1:0]   r_plh;
    logic [WA-HA+HB-1:0]   r_phl;
    logic [WP-HA-HB-1:0]   r_phh;
    logic [WP-1:0]         r_s0;
    logic [WP-1:0]         r_s1;
    logic [WP-1:0]         r_sum;
    logic signed [WP-1:0]  r_p;

    // magnitudes, then half-width partial products, then a two level sum, then the sign restored
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= i_a[WA-1] ? $unsigned(-i_a) : $unsigned(i_a);
            r_mb  <= i_b[WB-1] ? $unsigned(-i_b) : $unsigned(i_b);
            r_sg  <= {r_sg[2:0], i_a[WA-1] ^ i_b[WB-1]};
            r_pll <= r_ma[HA-1:0] * r_mb[HB-1:0];
            r_plh <= r_ma[HA-1:0] * r_mb[WB-1:HB];
            r_phl <= r_ma[WA-1:HA] * r_mb[HB-1:0];
            r_phh <= r_ma[WA-1:HA] * r_mb[WB-1:HB];
            r_s0  <= WP'(r_pll) + (WP'(r_phl) << HA);
            r_s1  <= (WP'(r_plh) << HB) + (WP'(r_phh) << (HA + HB));
            r_sum <= r_s0 + r_s1;
            r_p   <= $signed(r_sg[3] ? (~r_sum + 1'b1) : r_sum);
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/sci_sqrt_cell.sv =====
module sci_sqrt_cell import sci_pkg::*; #(
    parameter int K = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_v,
    input  logic [W_Q-1:0]    i_rem,
    input  logic [W_RT-1:0]   i_root,
    input  t_ctx              i_ctx,
    output logic              o_v,
    output logic [W_Q-1:0]    o_rem,
    output logic [W_RT-1:0]   o_root,
    output t_ctx              o_ctx
);

    logic [W_Q-1:0]  trial;
    logic            ge;
    logic            r_v;
    logic [W_Q-1:0]  r_rem;
    logic [W_RT-1:0] r_root;
    t_ctx            r_ctx;

    // try root bit K: (R + 2^K)^2 - R^2 against the remainder
    assign trial = (W_Q'(i_root) << (K + 1)) | (W_Q'(1) << (2 * K));
    assign ge    = (i_rem >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= ge ? (i_rem - trial) : i_rem;
            r_root <= i_root | (W_RT'(ge) << K);
            r_ctx  <= i_ctx;
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_ctx  = r_ctx;

endmodule

// ===== hw/rtl/sci_div_cell.sv =====
module sci_div_cell import sci_pkg::*; #(
    parameter int K = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_v,
    input  logic [W_N-1:0]    i_rem_x,
    input  logic [W_N-1:0]    i_rem_y,
    input  logic [W_QT-1:0]   i_qx,
    input  logic [W_QT-1:0]   i_qy,
    input  t_ctx              i_ctx,
    output logic              o_v,
    output logic [W_N-1:0]    o_rem_x,
    output logic [W_N-1:0]    o_rem_y,
    output logic [W_QT-1:0]   o_qx,
    output logic [W_QT-1:0]   o_qy,
    output t_ctx              o_ctx
);

    logic [W_N-1:0]  den;
    logic            ge_x;
    logic            ge_y;
    logic            r_v;
    logic [W_N-1:0]  r_rem_x;
    logic [W_N-1:0]  r_rem_y;
    logic [W_QT-1:0] r_qx;
    logic [W_QT-1:0] r_qy;
    t_ctx            r_ctx;

    // divisor 2a aligned to quotient bit K, shared by both lanes
    assign den  = W_N'($unsigned(i_ctx.a)) << (K + 1);
    assign ge_x = (i_rem_x >= den);
    assign ge_y = (i_rem_y >= den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x <= ge_x ? (i_rem_x - den) : i_rem_x;
            r_rem_y <= ge_y ? (i_rem_y - den) : i_rem_y;
            r_qx    <= i_qx | (W_QT'(ge_x) << K);
            r_qy    <= i_qy | (W_QT'(ge_y) << K);
            r_ctx   <= i_ctx;
        end
    end

    assign o_v     = r_v;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_ctx   = r_ctx;

endmodule

// ===== hw/rtl/segment_circle_intersect.sv =====
// throughput: one segment test per cycle while the output queue is not full, set by the row
//   of 68 root cells and 32 divide cells, each of which takes a new item every enabled cycle
// a two-entry output queue lets the pipe run while a result waits; the pipe halts when full
// reset: synchronous active low i_rst_n clears all valid bits and the output queue
module segment_circle_intersect import sci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // center_x, center_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y, circle_radius, pad
    input  logic [IN_W-1:0]    i_s_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // found, far_root, hit_x, hit_y, pad
    output logic [OUT_W-1:0]   o_m_axis_tdata
);

    logic en;
    logic in_fire;

    logic signed [W_C-1:0]  in_cx, in_cy, in_sx, in_sy, in_ex, in_ey;

    // stage 1: differences
    logic                   r_s1_v;
    logic signed [W_D-1:0]  r_s1_dx, r_s1_dy, r_s1_fx, r_s1_fy, r_s1_gx, r_s1_gy;
    logic signed [W_C-1:0]  r_s1_sx, r_s1_sy;
    logic [W_R2-1:0]        r_s1_r;

    // first products
    logic signed [2*W_D-1:0] p_dxx, p_dyy, p_fdx, p_fdy, p_fxx, p_fyy, p_gxx, p_gyy;
    logic signed [2*W_C-1:0] p_rr;
    logic                    r_d1_v [MUL_LAT];
    t_ctx                    r_d1_ctx [MUL_LAT];
    t_ctx                    ctx1;

    // stage A and B: coefficients
    t_ctx                   ctx2;
    logic                   r_s2_v;
    t_ctx                   r_s2_ctx;
    logic signed [W_V-1:0]  r_s2_f2, r_s2_g2, r_s2_rr;
    t_ctx                   ctx3;
    logic                   r_s3_v;
    t_ctx                   r_s3_ctx;

    // second products
    logic signed [2*W_V-1:0] p_hh, p_ac;
    logic                    r_d2_v [MUL_LAT];
    t_ctx                    r_d2_ctx [MUL_LAT];

    // stage C: discriminant and root tests
    logic signed [W_Q-1:0]  q_c;
    logic                   far_ok, near_ok;
    t_ctx                   ctx4;
    logic                   r_s4_v;
    logic [W_Q-1:0]         r_s4_q;
    t_ctx                   r_s4_ctx;

    // root chain
    logic                   sq_v    [W_RT+1];
    logic [W_Q-1:0]         sq_rem  [W_RT+1];
    logic [W_RT-1:0]        sq_root [W_RT+1];
    t_ctx                   sq_ctx  [W_RT+1];

    // stage D: numerator and step magnitudes
    logic signed [W_RT:0]   s_ext, h_ext, s_sel, num_ext;
    logic [W_D-1:0]         dxm, dym;
    logic                   r_s5_v;
    logic signed [W_V-1:0]  r_s5_num;
    logic [W_D-1:0]         r_s5_dxm, r_s5_dym;
    t_ctx                   r_s5_ctx;

    // third products
    logic signed [W_V+W_D:0] p_nx, p_ny;
    logic                    r_d3_v [MUL_LAT];
    t_ctx                    r_d3_ctx [MUL_LAT];

    // stage E registers feeding the divide chain
    logic                   r_e_v;
    logic [W_N-1:0]         r_e_rx, r_e_ry;
    t_ctx                   r_e_ctx;

    // divide chain
    logic                   dv_v   [W_QT+1];
    logic [W_N-1:0]         dv_rx  [W_QT+1];
    logic [W_N-1:0]         dv_ry  [W_QT+1];
    logic [W_QT-1:0]        dv_qx  [W_QT+1];
    logic [W_QT-1:0]        dv_qy  [W_QT+1];
    t_ctx                   dv_ctx [W_QT+1];

    // result and output queue
    t_ctx                   fin;
    logic [W_C-1:0]         hit_x, hit_y;
    logic [RES_W-1:0]       res;
    logic                   push, pop;
    logic [1:0]             r_cnt, n_cnt;
    logic [RES_W-1:0]       r_q0, r_q1, n_q0, n_q1;

    assign en              = (r_cnt != 2'd2);
    assign o_s_axis_tready = en;
    assign in_fire         = i_s_axis_tvalid & en;

    assign in_cx = $signed(i_s_axis_tdata[31:0]);
    assign in_cy = $signed(i_s_axis_tdata[63:32]);
    assign in_sx = $signed(i_s_axis_tdata[95:64]);
    assign in_sy = $signed(i_s_axis_tdata[127:96]);
    assign in_ex = $signed(i_s_axis_tdata[159:128]);
    assign in_ey = $signed(i_s_axis_tdata[191:160]);

    // stage 1: segment vector and offsets from the centre
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_dx <= W_D'(in_ex) - W_D'(in_sx);
            r_s1_dy <= W_D'(in_ey) - W_D'(in_sy);
            r_s1_fx <= W_D'(in_sx) - W_D'(in_cx);
            r_s1_fy <= W_D'(in_sy) - W_D'(in_cy);
            r_s1_gx <= W_D'(in_ex) - W_D'(in_cx);
            r_s1_gy <= W_D'(in_ey) - W_D'(in_cy);
            r_s1_sx <= in_sx;
            r_s1_sy <= in_sy;
            r_s1_r  <= i_s_axis_tdata[222:192];
        end
    end

    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_dxx (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_dx), .i_b(r_s1_dx), .o_p(p_dxx));
    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_dyy (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_dy), .i_b(r_s1_dy), .o_p(p_dyy));
    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_fdx (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_fx), .i_b(r_s1_dx), .o_p(p_fdx));
    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_fdy (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_fy), .i_b(r_s1_dy), .o_p(p_fdy));
    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_fxx (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_fx), .i_b(r_s1_fx), .o_p(p_fxx));
    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_fyy (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_fy), .i_b(r_s1_fy), .o_p(p_fyy));
    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_gxx (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_gx), .i_b(r_s1_gx), .o_p(p_gxx));
    sci_mul #(.WA(W_D), .WB(W_D)) u_mul_gyy (
        .i_clk(i_clk), .i_en(en), .i_a(r_s1_gy), .i_b(r_s1_gy), .o_p(p_gyy));
    sci_mul #(.WA(W_C), .WB(W_C)) u_mul_rr (
        .i_clk(i_clk), .i_en(en), .i_a($signed({1'b0, r_s1_r})),
        .i_b($signed({1'b0, r_s1_r})), .o_p(p_rr));

    always_comb begin
        ctx1    = '0;
        ctx1.sx = r_s1_sx;
        ctx1.sy = r_s1_sy;
        ctx1.dx = r_s1_dx;
        ctx1.dy = r_s1_dy;
    end

    // context delay alongside the first products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUL_LAT; i++) r_d1_v[i] <= 1'b0;
        end else if (en) begin
            r_d1_v[0] <= r_s1_v;
            for (int i = 1; i < MUL_LAT; i++) r_d1_v[i] <= r_d1_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_ctx[0] <= ctx1;
            for (int i = 1; i < MUL_LAT; i++) r_d1_ctx[i] <= r_d1_ctx[i-1];
        end
    end

    // stage A: sums of squares and the dot product
    always_comb begin
        ctx2   = r_d1_ctx[MUL_LAT-1];
        ctx2.a = W_V'(p_dxx) + W_V'(p_dyy);
        ctx2.h = W_V'(p_fdx) + W_V'(p_fdy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_d1_v[MUL_LAT-1];
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ctx <= ctx2;
            r_s2_f2  <= W_V'(p_fxx) + W_V'(p_fyy);
            r_s2_g2  <= W_V'(p_gxx) + W_V'(p_gyy);
            r_s2_rr  <= W_V'(p_rr);
        end
    end

    // stage B: c, e and a + h
    always_comb begin
        ctx3    = r_s2_ctx;
        ctx3.c  = r_s2_f2 - r_s2_rr;
        ctx3.e  = r_s2_g2 - r_s2_rr;
        ctx3.ah = r_s2_ctx.a + r_s2_ctx.h;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ctx <= ctx3;
        end
    end

    sci_mul #(.WA(W_V), .WB(W_V)) u_mul_hh (
        .i_clk(i_clk), .i_en(en), .i_a(r_s3_ctx.h), .i_b(r_s3_ctx.h), .o_p(p_hh));
    sci_mul #(.WA(W_V), .WB(W_V)) u_mul_ac (
        .i_clk(i_clk), .i_en(en), .i_a(r_s3_ctx.a), .i_b(r_s3_ctx.c), .o_p(p_ac));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUL_LAT; i++) r_d2_v[i] <= 1'b0;
        end else if (en) begin
            r_d2_v[0] <= r_s3_v;
            for (int i = 1; i < MUL_LAT; i++) r_d2_v[i] <= r_d2_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_ctx[0] <= r_s3_ctx;
            for (int i = 1; i < MUL_LAT; i++) r_d2_ctx[i] <= r_d2_ctx[i-1];
        end
    end

    // stage C: discriminant and which root lies on the segment
    always_comb begin
        ctx4    = r_d2_ctx[MUL_LAT-1];
        q_c     = W_Q'(p_hh) - W_Q'(p_ac);
        far_ok  = ((ctx4.h <= 0) || (ctx4.c <= 0)) && (ctx4.ah >= 0) && (ctx4.e >= 0);
        near_ok = (ctx4.h <= 0) && (ctx4.c >= 0) && ((ctx4.ah >= 0) || (ctx4.e <= 0));
        ctx4.far_ok = far_ok;
        ctx4.found  = (ctx4.a != '0) && !q_c[W_Q-1] && (far_ok || near_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_d2_v[MUL_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_q   <= $unsigned(q_c);
            r_s4_ctx <= ctx4;
        end
    end

    // integer square root, one bit per cell from the top
    assign sq_v[0]    = r_s4_v;
    assign sq_rem[0]  = r_s4_q;
    assign sq_root[0] = '0;
    assign sq_ctx[0]  = r_s4_ctx;

    for (genvar g = 0; g < W_RT; g++) begin : g_sqrt
        sci_sqrt_cell #(.K(W_RT - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (sq_v[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_ctx  (sq_ctx[g]),
            .o_v    (sq_v[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_ctx  (sq_ctx[g+1])
        );
    end

    // stage D: numerator of the chosen root, step magnitudes
    always_comb begin
        s_ext   = $signed({1'b0, sq_root[W_RT]});
        h_ext   = (W_RT + 1)'(sq_ctx[W_RT].h);
        s_sel   = sq_ctx[W_RT].far_ok ? s_ext : -s_ext;
        num_ext = s_sel - h_ext;
        dxm     = sq_ctx[W_RT].dx[W_D-1] ? $unsigned(-sq_ctx[W_RT].dx)
                                         : $unsigned(sq_ctx[W_RT].dx);
        dym     = sq_ctx[W_RT].dy[W_D-1] ? $unsigned(-sq_ctx[W_RT].dy)
                                         : $unsigned(sq_ctx[W_RT].dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= sq_v[W_RT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_num <= W_V'(num_ext);
            r_s5_dxm <= dxm;
            r_s5_dym <= dym;
            r_s5_ctx <= sq_ctx[W_RT];
        end
    end

    sci_mul #(.WA(W_V), .WB(W_D + 1)) u_mul_nx (
        .i_clk(i_clk), .i_en(en), .i_a(r_s5_num), .i_b($signed({1'b0, r_s5_dxm})),
        .o_p(p_nx));
    sci_mul #(.WA(W_V), .WB(W_D + 1)) u_mul_ny (
        .i_clk(i_clk), .i_en(en), .i_a(r_s5_num), .i_b($signed({1'b0, r_s5_dym})),
        .o_p(p_ny));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MUL_LAT; i++) r_d3_v[i] <= 1'b0;
        end else if (en) begin
            r_d3_v[0] <= r_s5_v;
            for (int i = 1; i < MUL_LAT; i++) r_d3_v[i] <= r_d3_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3_ctx[0] <= r_s5_ctx;
            for (int i = 1; i < MUL_LAT; i++) r_d3_ctx[i] <= r_d3_ctx[i-1];
        end
    end

    // stage E: rounding numerators 2*n*|d| + a
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_d3_v[MUL_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_rx  <= (W_N'($unsigned(p_nx)) << 1)
                       + W_N'($unsigned(r_d3_ctx[MUL_LAT-1].a));
            r_e_ry  <= (W_N'($unsigned(p_ny)) << 1)
                       + W_N'($unsigned(r_d3_ctx[MUL_LAT-1].a));
            r_e_ctx <= r_d3_ctx[MUL_LAT-1];
        end
    end

    assign dv_v[0]   = r_e_v;
    assign dv_rx[0]  = r_e_rx;
    assign dv_ry[0]  = r_e_ry;
    assign dv_ctx[0] = r_e_ctx;
    assign dv_qx[0]  = '0;
    assign dv_qy[0]  = '0;

    // restoring divide by 2a, one quotient bit per cell, both coordinates side by side
    for (genvar g = 0; g < W_QT; g++) begin : g_div
        sci_div_cell #(.K(W_QT - 1 - g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_v    (dv_v[g]),
            .i_rem_x(dv_rx[g]),
            .i_rem_y(dv_ry[g]),
            .i_qx   (dv_qx[g]),
            .i_qy   (dv_qy[g]),
            .i_ctx  (dv_ctx[g]),
            .o_v    (dv_v[g+1]),
            .o_rem_x(dv_rx[g+1]),
            .o_rem_y(dv_ry[g+1]),
            .o_qx   (dv_qx[g+1]),
            .o_qy   (dv_qy[g+1]),
            .o_ctx  (dv_ctx[g+1])
        );
    end

    // final point, zeroed when there is no hit
    always_comb begin
        fin   = dv_ctx[W_QT];
        hit_x = $unsigned(fin.sx) + (fin.dx[W_D-1] ? (~dv_qx[W_QT] + 1'b1) : dv_qx[W_QT]);
        hit_y = $unsigned(fin.sy) + (fin.dy[W_D-1] ? (~dv_qy[W_QT] + 1'b1) : dv_qy[W_QT]);
        if (fin.found) begin
            res = {hit_y, hit_x, fin.far_ok, 1'b1};
        end else begin
            res = '0;
        end
    end

    // two-entry output queue
    assign push = dv_v[W_QT] & en;
    assign pop  = o_m_axis_tvalid & i_m_axis_tready;

    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        case ({push, pop})
            2'b10: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd0) n_q0 = res;
                else n_q1 = res;
            end
            2'b01: begin
                n_cnt = r_cnt - 2'd1;
                n_q0  = r_q1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_q0 = res;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = res;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = {(OUT_W - RES_W)'(0), r_q0};

    // queue never overfills
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    // a miss carries no root choice and no point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[RES_W-1:1] == '0))
        else $error("miss result with nonzero fields");

    // a transfer out with nothing coming in lowers the count by one
    a_pop_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("queue count did not follow a transfer");

    // a full queue holds the pipe, so no result is pushed into it
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2 && $stable(r_q1)))
        else $error("result entered a full queue");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sci_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 300;

    typedef logic signed [159:0] t_wide;
    typedef logic [159:0]        t_uwide;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [30:0]        rad;
    } t_seg_item;

    typedef struct {
        logic        found;
        logic        far_root;
        logic [31:0] hit_x;
        logic [31:0] hit_y;
    } t_hit;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [IN_W-1:0]  s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [OUT_W-1:0] m_data;

    t_hit hit_q[$];
    int   error_count = 0;
    int   idle_count = 0;
    bit   no_idle = 1'b0;
    int   hold_cycles = 0;
    int   stall_left = 0;
    bit   took = 1'b0;

    segment_circle_intersect dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // exact isqrt, floor
    function automatic t_uwide isqrt_floor(t_uwide x);
        t_uwide res, bits, t;
        res = '0;
        bits = t_uwide'(1) << 158;
        while (bits != 0 && bits > x) bits = bits >> 2;
        while (bits != 0) begin
            t = res + bits;
            if (x >= t) begin
                x = x - t;
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // start + round(num * d / a), ties away from zero
    function automatic logic [31:0] move_along(logic signed [31:0] st, t_wide num,
                                               t_wide d, t_wide a);
        t_uwide mag, n2, qt;
        logic [63:0] r64, sum;
        mag = (d < 0) ? t_uwide'(-d) : t_uwide'(d);
        n2 = ((t_uwide'(num) * mag) << 1) + t_uwide'(a);
        qt = n2 / (t_uwide'(a) << 1);
        r64 = qt[63:0];
        if (d < 0) r64 = -r64;
        sum = {{32{st[31]}}, st} + r64;
        return sum[31:0];
    endfunction

    // expected intersection for one query
    function automatic t_hit predict_hit(t_seg_item it);
        t_wide dx, dy, fx, fy, gx, gy, rr, r2, a, h, c, e, q, ah, s, num;
        bit far_ok, near_ok;
        t_hit res;
        res = '{1'b0, 1'b0, 32'd0, 32'd0};
        dx = $signed(it.ex) - $signed(it.sx);
        dy = $signed(it.ey) - $signed(it.sy);
        fx = $signed(it.sx) - $signed(it.cx);
        fy = $signed(it.sy) - $signed(it.cy);
        gx = $signed(it.ex) - $signed(it.cx);
        gy = $signed(it.ey) - $signed(it.cy);
        rr = {129'd0, it.rad};
        r2 = rr * rr;
        a = dx * dx + dy * dy;
        h = fx * dx + fy * dy;
        c = fx * fx + fy * fy - r2;
        e = gx * gx + gy * gy - r2;
        q = h * h - a * c;
        ah = a + h;
        if (a == 0 || q < 0) return res;
        far_ok = (h <= 0 || c <= 0) && ah >= 0 && e >= 0;
        near_ok = h <= 0 && c >= 0 && (ah >= 0 || e <= 0);
        if (!far_ok && !near_ok) return res;
        s = t_wide'(isqrt_floor(t_uwide'(q)));
        num = far_ok ? (s - h) : (-h - s);
        res.found = 1'b1;
        res.far_root = far_ok;
        res.hit_x = move_along(it.sx, num, dx, a);
        res.hit_y = move_along(it.sy, num, dy, a);
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        error_count++;
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // one query transfer, with a random gap in front
    task automatic send_item(t_seg_item it);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_valid = 1'b0;
        end
        @(negedge i_clk);
        s_valid = 1'b1;
        s_data = {1'b0, it.rad, it.ey, it.ex, it.sy, it.sx, it.cy, it.cx};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        hit_q.push_back(predict_hit(it));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_valid = 1'b0;
    endtask

    task automatic wait_results();
        while (hit_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_scaled(int k);
        logic [31:0] v;
        v = $urandom();
        if (k < 32) v = $signed(v) >>> (32 - k);
        return v;
    endfunction

    // mostly segments near the circle, some raw noise
    function automatic t_seg_item rand_item();
        t_seg_item it;
        int k;
        if ($urandom_range(0, 7) == 0) begin
            it = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   31'($urandom())};
            return it;
        end
        k = $urandom_range(3, 29);
        it.cx = $urandom();
        it.cy = $urandom();
        if ($urandom_range(0, 1)) begin
            it.cx = $signed(it.cx) >>> 2;
            it.cy = $signed(it.cy) >>> 2;
        end
        it.rad = 31'($urandom() >> (32 - k));
        it.sx = it.cx + rand_scaled(k + 1);
        it.sy = it.cy + rand_scaled(k + 1);
        it.ex = it.cx + rand_scaled(k + 1);
        it.ey = it.cy + rand_scaled(k + 1);
        if ($urandom_range(0, 9) == 0) begin
            it.ex = it.sx;
            it.ey = it.sy;
        end
        return it;
    endfunction

    // reset, idle and transfer watchdog
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result checking at the rising edge
    always @(posedge i_clk) begin
        t_hit got, want;
        took = 1'b0;
        if (i_rst_n && m_valid && m_ready) begin
            took = 1'b1;
            got.found = m_data[0];
            got.far_root = m_data[1];
            got.hit_x = m_data[33:2];
            got.hit_y = m_data[65:34];
            if (hit_q.size() == 0) begin
                $display("unexpected result %h", m_data);
                error_count++;
            end else begin
                want = hit_q.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", 32'(got.found), 32'(want.found));
                if (got.far_root !== want.far_root)
                    report_mismatch("far_root", 32'(got.far_root), 32'(want.far_root));
                if (got.hit_x !== want.hit_x)
                    report_mismatch("hit_x", got.hit_x, want.hit_x);
                if (got.hit_y !== want.hit_y)
                    report_mismatch("hit_y", got.hit_y, want.hit_y);
            end
        end
    end

    // receiver ready, with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (took) stall_left = draw_gap();
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        localparam logic signed [31:0] ONE = 32'sh0001_0000;
        localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        localparam logic [30:0] R_ONE = 31'h0001_0000;
        t_seg_item d[$];
        // all zeros: zero-length segment
        d.push_back('{0, 0, 0, 0, 0, 0, 31'd0});
        // zero-length segment on the circle
        d.push_back('{0, 0, ONE, 0, ONE, 0, R_ONE});
        // through the centre, far root from inside
        d.push_back('{0, 0, 0, 0, 2 * ONE, 0, R_ONE});
        // entering from outside, near root
        d.push_back('{0, 0, -2 * ONE, 0, 0, 0, R_ONE});
        // crossing fully, both roots on the segment
        d.push_back('{0, 0, -2 * ONE, ONE / 2, 2 * ONE, ONE / 2, R_ONE});
        // miss: negative discriminant
        d.push_back('{0, 0, -2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, R_ONE});
        // tangent
        d.push_back('{0, 0, -2 * ONE, ONE, 2 * ONE, ONE, R_ONE});
        // segment wholly inside
        d.push_back('{0, 0, -ONE / 4, 0, ONE / 4, 0, R_ONE});
        // segment short of the circle
        d.push_back('{0, 0, -4 * ONE, 0, -3 * ONE, 0, R_ONE});
        // segment pointing away
        d.push_back('{0, 0, 3 * ONE, 0, 4 * ONE, 0, R_ONE});
        // endpoints exactly on the circle
        d.push_back('{0, 0, -ONE, 0, ONE, 0, R_ONE});
        // zero radius, segment through the centre
        d.push_back('{0, 0, -ONE, -ONE, ONE, ONE, 31'd0});
        // coordinate extremes
        d.push_back('{MINV, MINV, MINV, MINV, MAXV, MAXV, 31'h7fff_ffff});
        d.push_back('{MAXV, MAXV, MINV, MAXV, MAXV, MINV, 31'h7fff_ffff});
        d.push_back('{MINV, MAXV, MAXV, MINV, MINV, MAXV, 31'h4000_0000});
        d.push_back('{0, 0, MINV, 0, MAXV, 0, 31'h7fff_ffff});
        d.push_back('{MAXV, MINV, 0, 0, MAXV, MINV, 31'd1});
        d.push_back('{-1, -1, MAXV, MAXV, MINV, MINV, 31'h7fff_ffff});
        // tiny steps, rounding ties
        d.push_back('{0, 0, 0, 0, 3, 1, 31'd2});
        d.push_back('{1, 1, -1, 0, 1, 3, 31'd1});
        foreach (d[i]) send_item(d[i]);
        end_burst();
        wait_results();
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            if ($urandom_range(0, 199) == 0) no_idle = ~no_idle;
            send_item(rand_item());
        end
        no_idle = 1'b0;
        end_burst();
    endtask

    task automatic test_backpressure();
        no_idle = 1'b1;
        @(negedge i_clk);
        hold_cycles = 400;
        repeat (160) send_item(rand_item());
        end_burst();
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (30) send_item(rand_item());
        end_burst();
        wait_results();
        repeat (30) send_item(rand_item());
        end_burst();
    endtask

    initial begin
        @(posedge i_rst_n);
        test_directed();
        test_random(600);
        test_backpressure();
        test_drain_pause();
        test_random(500);
        wait_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
